@@ rtl/core/ttsr_pkg.sv @@
package ttsr_pkg;

  localparam int unsigned MAX_PER_SEGMENT_DEF = 62;
  localparam int unsigned FRAC_BITS_DEF       = 16;

  localparam logic [31:0] STEP_RST    = 32'd655;
  localparam logic [15:0] COUNT_RST   = 16'd100;
  localparam logic [31:0] INVSCL_RST  = 32'd65536;
  localparam logic [31:0] HEADING_RST = 32'd0;

  typedef enum logic [1:0] {
    CFG_STEP    = 2'd0,
    CFG_COUNT   = 2'd1,
    CFG_INVSCL  = 2'd2,
    CFG_HEADING = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0]        point_time;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_vel_x;
    logic signed [31:0] point_vel_y;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               end_record;
  } out_item_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // capture the input item
    OP_SCL_CUR,  // scale current x/y/vx/vy (four multiplier passes)
    OP_SCL_PREV, // scale previous x/y
    OP_SLOPE,    // start slope divisions
    OP_TARGET,   // compute target time for current index
    OP_RATIO,    // start ratio division
    OP_INTERP,   // interpolate x/y from ratio
    OP_ADV,      // advance sample index and emitted count
    OP_COMMIT    // store current point as previous
  } dp_op_t;

  typedef enum logic [1:0] {
    REC_START,
    REC_SAMPLE,
    REC_END
  } rec_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     out_load;
    rec_sel_t rec;
    logic     clear_traj;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;        // multiplier or divider still running
    logic have_prev;
    logic last;
    logic forward;     // t > prev_time
    logic more;        // index + 1 < sample_count
    logic in_seg;      // target in [start, end)
    logic cap_left;    // emitted < MAX_PER_SEGMENT
    logic out_full;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCALE,
    ST_START_REC,
    ST_SCALE_PREV,
    ST_SLOPE,
    ST_TARGET,
    ST_CHECK,
    ST_RATIO,
    ST_INTERP,
    ST_EMIT,
    ST_ADV,
    ST_COMMIT,
    ST_END_REC
  } ctl_state_t;

endpackage

@@ rtl/core/ttsr_div.sv @@
module ttsr_div
  import ttsr_pkg::*;
#(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]   trial;

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;

  // One quotient bit per cycle, restoring
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, quo_r[NUM_W-1]};
    if (start) begin
      quo_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, den}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

endmodule

@@ rtl/core/ttsr_datapath.sv @@
module ttsr_datapath
  import ttsr_pkg::*;
#(
  parameter int unsigned MAX_PER_SEGMENT = MAX_PER_SEGMENT_DEF,
  parameter int unsigned FRAC_BITS       = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  in_item_t    in_data,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int unsigned EMIT_W = $clog2(MAX_PER_SEGMENT + 1);
  localparam logic [EMIT_W-1:0] EMIT_MAX = EMIT_W'(MAX_PER_SEGMENT);
  localparam int unsigned DNUM_W = 32 + FRAC_BITS + 1;

  // Configuration registers
  logic [31:0] step_r, invscl_r, heading_r;
  logic [15:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= STEP_RST;
      count_r   <= COUNT_RST;
      invscl_r  <= INVSCL_RST;
      heading_r <= HEADING_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP:    step_r    <= cfg_data;
        CFG_COUNT:   count_r   <= cfg_data[15:0];
        CFG_INVSCL:  invscl_r  <= cfg_data;
        CFG_HEADING: heading_r <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Trajectory state
  logic [31:0]        prev_t_r;
  logic signed [31:0] prev_x_r, prev_y_r;
  logic [15:0]        idx_r;
  logic               have_prev_r;
  logic [EMIT_W-1:0]  emit_r;

  // Working registers
  in_item_t           cur_r;
  logic signed [31:0] sx_r, sy_r, svx_r, svy_r;   // scaled current
  logic signed [31:0] px_r, py_r;                 // scaled previous
  logic signed [31:0] slx_r, sly_r;
  logic [47:0]        target_r;
  logic [FRAC_BITS:0] ratio_r;
  logic signed [31:0] ix_r, iy_r;
  logic [2:0]         mcnt_r;    // 0..5 scale operands, 6/7 interpolate x/y
  logic               mbusy_r;
  logic [2:0]         ptag_r;    // operand index of the product in prod_r
  logic signed [63:0] prod_r;
  logic               plive_r;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647)       return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  // Segment deltas between scaled positions
  logic signed [32:0] dx, dy;
  assign dx = 33'(sx_r) - 33'(px_r);
  assign dy = 33'(sy_r) - 33'(py_r);

  // Shared multiplier: one 32x33 product per cycle, registered
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [63:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = $signed({1'b0, invscl_r});
    unique case (mcnt_r)
      3'd0: mul_a = cur_r.point_x;
      3'd1: mul_a = cur_r.point_y;
      3'd2: mul_a = cur_r.point_vel_x;
      3'd3: mul_a = cur_r.point_vel_y;
      3'd4: mul_a = prev_x_r;
      3'd5: mul_a = prev_y_r;
      3'd6: begin
        mul_a = $signed(32'(ratio_r));
        mul_b = dx;
      end
      3'd7: begin
        mul_a = $signed(32'(ratio_r));
        mul_b = dy;
      end
    endcase
  end
  assign mul_p = 64'(mul_a * mul_b);

  // Scaling result: floor shift then saturate
  logic signed [31:0] scl_res;
  assign scl_res = sat32(66'(prod_r >>> FRAC_BITS));

  // Divider: shared by slope x, slope y and ratio
  logic              div_start, div_busy;
  logic [DNUM_W-1:0] div_num, div_quo;
  logic [31:0]       div_den;
  logic [1:0]        dsel_r;  // 0 slope x, 1 slope y, 2 ratio
  logic              dlive_r;
  logic              dneg_r;
  logic [32:0]       dmag;

  assign div_den = cur_r.point_time - prev_t_r;

  ttsr_div #(.NUM_W(DNUM_W), .DEN_W(32)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quo  (div_quo)
  );

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    dmag      = '0;
    if (cmd.op == OP_SLOPE || (dlive_r && !div_busy && dsel_r == 2'd0)) begin
      div_start = 1'b1;
      if (cmd.op == OP_SLOPE) dmag = dx[32] ? 33'(-dx) : 33'(dx);
      else                    dmag = dy[32] ? 33'(-dy) : 33'(dy);
      div_num = DNUM_W'({dmag, {FRAC_BITS{1'b0}}});
    end else if (cmd.op == OP_RATIO) begin
      div_start = 1'b1;
      div_num   = DNUM_W'({32'(target_r - 48'(prev_t_r)), {FRAC_BITS{1'b0}}});
    end
  end

  // Signed slope from magnitude quotient (truncation toward zero)
  logic signed [65:0] sq;
  assign sq = dneg_r ? -$signed(66'(div_quo)) : $signed(66'(div_quo));

  // Interpolated position: start + floor(delta*ratio >> F)
  logic signed [65:0] ipos;
  assign ipos = 66'(ptag_r[0] ? py_r : px_r) + 66'(prod_r >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      plive_r <= 1'b0;
      dlive_r <= 1'b0;
      mcnt_r  <= '0;
      ptag_r  <= '0;
      dsel_r  <= '0;
      dneg_r  <= 1'b0;
    end else begin
      // A product issued this cycle is in prod_r on the next one
      plive_r <= mbusy_r;
      ptag_r  <= mcnt_r;
      if (cmd.op == OP_SCL_CUR) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= 3'd0;
      end else if (cmd.op == OP_SCL_PREV) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= 3'd4;
      end else if (cmd.op == OP_INTERP) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= 3'd6;
      end else if (mbusy_r) begin
        if (mcnt_r == 3'd3 || mcnt_r == 3'd5 || mcnt_r == 3'd7) begin
          mbusy_r <= 1'b0;
        end
        mcnt_r <= mcnt_r + 1'b1;
      end
      // Divider sequencing
      if (cmd.op == OP_SLOPE) begin
        dlive_r <= 1'b1;
        dsel_r  <= 2'd0;
        dneg_r  <= dx[32];
      end else if (cmd.op == OP_RATIO) begin
        dlive_r <= 1'b1;
        dsel_r  <= 2'd2;
        dneg_r  <= 1'b0;
      end else if (dlive_r && !div_busy) begin
        if (dsel_r == 2'd0) begin
          dsel_r <= 2'd1;
          dneg_r <= dy[32];
        end else begin
          dlive_r <= 1'b0;
        end
      end
    end
  end

  // Capture products and quotients
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (plive_r) begin
      unique case (ptag_r)
        3'd0: sx_r  <= scl_res;
        3'd1: sy_r  <= scl_res;
        3'd2: svx_r <= scl_res;
        3'd3: svy_r <= scl_res;
        3'd4: px_r  <= scl_res;
        3'd5: py_r  <= scl_res;
        3'd6: ix_r  <= sat32(ipos);
        3'd7: iy_r  <= sat32(ipos);
      endcase
    end
    if (dlive_r && !div_busy && !div_start) begin
      if (dsel_r == 2'd1) sly_r <= sat32(sq);
      else if (dsel_r == 2'd2) ratio_r <= div_quo[FRAC_BITS:0];
    end
    if (dlive_r && !div_busy && dsel_r == 2'd0) slx_r <= sat32(sq);
    if (cmd.op == OP_TARGET) target_r <= 48'(idx_r) * 48'(step_r);
    if (cmd.op == OP_LOAD) cur_r <= in_data;
  end

  // Trajectory state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_t_r    <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      idx_r       <= 16'd1;
      have_prev_r <= 1'b0;
      emit_r      <= '0;
    end else begin
      if (cmd.op == OP_SLOPE) emit_r <= '0;
      if (cmd.op == OP_ADV) begin
        idx_r <= idx_r + 1'b1;
        if (emit_r != EMIT_MAX) emit_r <= emit_r + 1'b1;
      end
      if (cmd.op == OP_COMMIT) begin
        prev_t_r    <= cur_r.point_time;
        prev_x_r    <= cur_r.point_x;
        prev_y_r    <= cur_r.point_y;
        have_prev_r <= 1'b1;
      end
      if (cmd.clear_traj) begin
        prev_t_r    <= '0;
        prev_x_r    <= '0;
        prev_y_r    <= '0;
        idx_r       <= 16'd1;
        have_prev_r <= 1'b0;
      end
    end
  end

  // Output register
  out_item_t out_r;
  logic      out_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_r.heading    <= heading_r;
      out_r.end_record <= (cmd.rec == REC_END);
      if (cmd.rec == REC_SAMPLE) begin
        out_r.pos_x <= ix_r;
        out_r.pos_y <= iy_r;
        out_r.vel_x <= slx_r;
        out_r.vel_y <= sly_r;
      end else begin
        out_r.pos_x <= sx_r;
        out_r.pos_y <= sy_r;
        out_r.vel_x <= svx_r;
        out_r.vel_y <= svy_r;
      end
    end
  end
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Status
  always_comb begin
    stat.busy      = mbusy_r | plive_r | dlive_r | div_busy;
    stat.have_prev = have_prev_r;
    stat.last      = cur_r.last_point;
    stat.forward   = cur_r.point_time > prev_t_r;
    stat.more      = (17'(idx_r) + 17'd1) < 17'(count_r);
    stat.in_seg    = (target_r >= 48'(prev_t_r)) && (target_r < 48'(cur_r.point_time));
    stat.cap_left  = emit_r != EMIT_MAX;
    stat.out_full  = out_v_r && out_stall;
  end

`ifndef SYNTHESIS
  a_emit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r <= EMIT_MAX) else $error("emit count past cap");
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall) |-> !cmd.out_load) else $error("output overwritten");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall) |=> $stable(out_r)) else $error("stalled output moved");
`endif

endmodule

@@ rtl/core/ttsr_ctrl.sv @@
module ttsr_ctrl
  import ttsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Sequence one point through scale, slope, sample loop and records
  always_comb begin
    state_nxt      = state_r;
    cmd.op         = OP_NONE;
    cmd.out_load   = 1'b0;
    cmd.rec        = REC_SAMPLE;
    cmd.clear_traj = 1'b0;
    in_stall       = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.op    = OP_SCL_CUR;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (!stat.busy) begin
          if (!stat.have_prev) state_nxt = ST_START_REC;
          else if (stat.forward) begin
            cmd.op    = OP_SCL_PREV;
            state_nxt = ST_SCALE_PREV;
          end else state_nxt = ST_COMMIT;
        end
      end
      ST_START_REC: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          cmd.rec      = REC_START;
          state_nxt    = ST_COMMIT;
        end
      end
      ST_SCALE_PREV: begin
        if (!stat.busy) begin
          cmd.op    = OP_SLOPE;
          state_nxt = ST_SLOPE;
        end
      end
      ST_SLOPE: begin
        if (!stat.busy) state_nxt = ST_TARGET;
      end
      ST_TARGET: begin
        if (stat.more) begin
          cmd.op    = OP_TARGET;
          state_nxt = ST_CHECK;
        end else state_nxt = ST_COMMIT;
      end
      ST_CHECK: begin
        if (!stat.in_seg)       state_nxt = ST_COMMIT;
        else if (stat.cap_left) begin
          cmd.op    = OP_RATIO;
          state_nxt = ST_RATIO;
        end else state_nxt = ST_ADV;
      end
      ST_RATIO: begin
        if (!stat.busy) begin
          cmd.op    = OP_INTERP;
          state_nxt = ST_INTERP;
        end
      end
      ST_INTERP: begin
        if (!stat.busy) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_ADV;
        end
      end
      ST_ADV: begin
        cmd.op    = OP_ADV;
        state_nxt = ST_TARGET;
      end
      ST_COMMIT: begin
        cmd.op    = OP_COMMIT;
        state_nxt = stat.last ? ST_END_REC : ST_IDLE;
      end
      ST_END_REC: begin
        if (!stat.out_full) begin
          cmd.out_load   = 1'b1;
          cmd.rec        = REC_END;
          cmd.clear_traj = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == ST_LOAD) else $error("accept not loaded");
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (cmd.op == OP_NONE)) else $error("load with op");
  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_traj |-> cmd.rec == REC_END) else $error("clear outside end");
`endif

endmodule

@@ rtl/core/trajectory_time_scaled_resampler.sv @@
// An accepted first point is loaded and scaled, then its start record is registered
// to the output. A later point that is forward in time is scaled with the previous
// one and its slopes are divided bit-serially; each sample's ratio is then divided,
// interpolated and emitted, or skipped past the per-segment cap. Output stalls hold
// the sequence, and a new point is taken only once the last one is through.
// Reset: synchronous active-low rst_n restores registers and trajectory state.
module trajectory_time_scaled_resampler
  import ttsr_pkg::*;
#(
  parameter int unsigned MAX_PER_SEGMENT = MAX_PER_SEGMENT_DEF,
  parameter int unsigned FRAC_BITS       = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ttsr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  ttsr_datapath #(
    .MAX_PER_SEGMENT(MAX_PER_SEGMENT),
    .FRAC_BITS      (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
